// ===== rtl/strict_priority_egress_queue_assert.svh =====
`ifndef STRICT_PRIORITY_EGRESS_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_EGRESS_QUEUE_ASSERT_SVH

// next-cycle implication, clocked on clk, off during rst
`define SPEQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("speq assertion failed");

// same-cycle implication, clocked on clk, off during rst
`define SPEQ_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("speq assertion failed");

`endif

// ===== rtl/speq_pkg.sv =====
package speq_pkg;

  localparam int HANDLE_W = 10;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

// ===== rtl/strict_priority_egress_queue.sv =====
// Strict-priority egress queue: one FIFO of packet handles per priority level,
// all held in a single memory. A word is accepted when start is high and busy is
// low; busy then goes high while the queue pointers update and the memory is
// read, and the result appears in the cycle after busy with done high for
// exactly one cycle. The result handle comes from the registered read port of
// the handle memory, so out_handle is registered. The receiver cannot stall:
// done is never held, so the result must be captured in the cycle it is shown.
// busy is low while done is high, so the next word may be presented in that
// cycle; no new word is taken while busy is high.
module strict_priority_egress_queue #(
  parameter int NUM_PRIOS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [speq_pkg::PRIO_W-1:0]   prio,
  input  logic [speq_pkg::HANDLE_W-1:0] handle,
  output logic                          done,
  output logic [speq_pkg::STATUS_W-1:0] status,
  output logic [speq_pkg::HANDLE_W-1:0] out_handle,
  output logic [speq_pkg::PRIO_W-1:0]   out_prio,
  output logic                          any_queued
);

  speq_pkg::ctl_cmd_t cmd;

  speq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  speq_dp #(
    .NUM_PRIOS   (NUM_PRIOS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .prio       (prio),
    .handle     (handle),
    .status     (status),
    .out_handle (out_handle),
    .out_prio   (out_prio),
    .any_queued (any_queued)
  );

endmodule

// ===== rtl/speq_ctrl.sv =====
module speq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output speq_pkg::ctl_cmd_t cmd
);

  speq_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= speq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state == speq_pkg::S_EXEC);
    done       = (state == speq_pkg::S_RESP);
    cmd.load   = start && !busy;
    cmd.exec   = (state == speq_pkg::S_EXEC);
    unique case (state)
      speq_pkg::S_IDLE: begin
        if (start) state_next = speq_pkg::S_EXEC;
      end
      speq_pkg::S_EXEC: begin
        state_next = speq_pkg::S_RESP;
      end
      speq_pkg::S_RESP: begin
        state_next = start ? speq_pkg::S_EXEC : speq_pkg::S_IDLE;
      end
      default: begin
        state_next = speq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/speq_dp.sv =====
module speq_dp #(
  parameter int NUM_PRIOS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  speq_pkg::ctl_cmd_t                  cmd,
  input  logic                                op,
  input  logic [speq_pkg::PRIO_W-1:0]         prio,
  input  logic [speq_pkg::HANDLE_W-1:0]       handle,
  output logic [speq_pkg::STATUS_W-1:0]       status,
  output logic [speq_pkg::HANDLE_W-1:0]       out_handle,
  output logic [speq_pkg::PRIO_W-1:0]         out_prio,
  output logic                                any_queued
);

  localparam int QW = $clog2(NUM_PRIOS);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_PRIOS * QUEUE_DEPTH;
  localparam int AW = $clog2(ENTRIES);
  localparam int SW = (HANDLE_BITS < speq_pkg::HANDLE_W) ? HANDLE_BITS : speq_pkg::HANDLE_W;
  localparam int XW = 5;

  speq_pkg::op_t               op_q;
  logic [speq_pkg::PRIO_W-1:0] prio_q;
  logic [SW-1:0]               handle_q;

  logic [PW-1:0] head [NUM_PRIOS];
  logic [PW-1:0] tail [NUM_PRIOS];
  logic [CW-1:0] fill [NUM_PRIOS];

  logic [SW-1:0] mem [ENTRIES];
  logic [SW-1:0] rdata;

  speq_pkg::status_t           status_q;
  logic                        hit_q;
  logic [speq_pkg::PRIO_W-1:0] oprio_q;

  logic [NUM_PRIOS-1:0] nonempty;
  logic                 deq_found;
  logic [QW-1:0]        deq_q;
  logic [XW-1:0]        prio_ext;
  logic [QW-1:0]        enq_q;
  logic                 enq_ok;
  logic                 do_enq;
  logic                 do_deq;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_PRIOS; i++) begin
      nonempty[i] = (fill[i] != '0);
    end
  end

  always_comb begin
    deq_found = 1'b0;
    deq_q     = '0;
    for (int i = 0; i < NUM_PRIOS; i++) begin
      if (nonempty[i]) begin
        deq_found = 1'b1;
        deq_q     = QW'(i);
      end
    end
  end

  assign prio_ext = XW'(prio_q);
  assign enq_q    = prio_ext[QW-1:0];
  assign enq_ok   = (prio_ext < XW'(NUM_PRIOS)) && (fill[enq_q] != CW'(QUEUE_DEPTH));
  assign do_enq   = cmd.exec && (op_q == speq_pkg::OP_ENQ) && enq_ok;
  assign do_deq   = cmd.exec && (op_q == speq_pkg::OP_DEQ) && deq_found;
  assign wr_addr  = AW'(AW'(enq_q) * AW'(QUEUE_DEPTH)) + AW'(tail[enq_q]);
  assign rd_addr  = AW'(AW'(deq_q) * AW'(QUEUE_DEPTH)) + AW'(head[deq_q]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= speq_pkg::op_t'(op);
      prio_q   <= prio;
      handle_q <= handle[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_addr] <= handle_q;
    end
  end

  always_ff @(posedge clk) begin
    if (do_deq) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '{default: '0};
      tail <= '{default: '0};
      fill <= '{default: '0};
    end else if (do_enq) begin
      tail[enq_q] <= ptr_inc(tail[enq_q]);
      fill[enq_q] <= fill[enq_q] + CW'(1);
    end else if (do_deq) begin
      head[deq_q] <= ptr_inc(head[deq_q]);
      fill[deq_q] <= fill[deq_q] - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_q == speq_pkg::OP_ENQ) begin
        status_q <= enq_ok ? speq_pkg::ST_OK : speq_pkg::ST_DROP;
      end else begin
        status_q <= deq_found ? speq_pkg::ST_OK : speq_pkg::ST_EMPTY;
      end
      hit_q   <= (op_q == speq_pkg::OP_DEQ) && deq_found;
      oprio_q <= ((op_q == speq_pkg::OP_DEQ) && deq_found) ? speq_pkg::PRIO_W'(deq_q) : '0;
    end
  end

  assign status     = status_q;
  assign out_handle = hit_q ? speq_pkg::HANDLE_W'(rdata) : '0;
  assign out_prio   = oprio_q;
  assign any_queued = |nonempty;

endmodule

// ===== rtl/speq_chk.sv =====
`include "strict_priority_egress_queue_assert.svh"

module speq_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [speq_pkg::STATUS_W-1:0] status,
  input logic [speq_pkg::HANDLE_W-1:0] out_handle,
  input logic [speq_pkg::PRIO_W-1:0]   out_prio,
  input logic                          any_queued
);

  logic out_zero;

  assign out_zero = (out_handle == '0) && (out_prio == '0);

  `SPEQ_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy && !done)
  `SPEQ_ASSERT_NOW(a_done_two_after, start && !busy, ##2 done)
  `SPEQ_ASSERT_NOW(a_done_not_busy, done, !busy)
  `SPEQ_ASSERT_NOW(a_empty_clean, done && (status == speq_pkg::ST_EMPTY), out_zero && !any_queued)
  `SPEQ_ASSERT_NOW(a_drop_clean, done && (status == speq_pkg::ST_DROP), out_zero)

endmodule

bind strict_priority_egress_queue speq_chk u_chk (.*);
